// ===== hw/rtl/shcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shcd_pkg: shared types and constants of the soft/hard clip distortion unit
// Holds the datapath widths, configuration register map, the exponential
// lookup tables and the structs passed between the unit's modules.
// ----------------------------------------------------------------------------
package shcd_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int CHANNELS        = 2;

	localparam int FRAC_BITS = SAMPLE_BITS - 1;
	localparam int TAB_AW    = $clog2(EXP_TABLE_DEPTH);
	localparam int RANGE_SH  = 4;

	localparam int PRE_W    = 12;
	localparam int DRV_W    = 15;
	localparam int MIX_W    = 13;
	localparam int MIX_ONE  = 4096;
	localparam int MIX_SH   = 12;
	localparam int GAIN_SH  = 8;

	// Datapath widths: product of pregain, dry sample, drive product, wet sample.
	localparam int P_W  = SAMPLE_BITS + PRE_W + 1;
	localparam int D_W  = P_W - GAIN_SH;
	localparam int WP_W = D_W + DRV_W + 1;
	localparam int W_W  = WP_W - GAIN_SH;
	localparam int MP_W = D_W + MIX_W + 1;

	// Table entries are Q1.30 values of exp(-t), at most 1.0.
	localparam int     EXP_W   = 31;
	localparam longint Q30_ONE = longint'(1) << 30;

	// Step factor exp(-16/DEPTH) from a Taylor series in Q2.30. Each term is
	// the previous one times the step over k, floored. Eight terms reach zero
	// for every table depth of 64 and up.
	localparam longint EXP_STEP = (longint'(16) << 30) / EXP_TABLE_DEPTH;
	localparam longint EXP_T1   = (Q30_ONE * EXP_STEP) / (longint'(1) << 30);
	localparam longint EXP_T2   = (EXP_T1 * EXP_STEP) / (longint'(2) << 30);
	localparam longint EXP_T3   = (EXP_T2 * EXP_STEP) / (longint'(3) << 30);
	localparam longint EXP_T4   = (EXP_T3 * EXP_STEP) / (longint'(4) << 30);
	localparam longint EXP_T5   = (EXP_T4 * EXP_STEP) / (longint'(5) << 30);
	localparam longint EXP_T6   = (EXP_T5 * EXP_STEP) / (longint'(6) << 30);
	localparam longint EXP_T7   = (EXP_T6 * EXP_STEP) / (longint'(7) << 30);
	localparam longint EXP_T8   = (EXP_T7 * EXP_STEP) / (longint'(8) << 30);
	localparam longint EXP_DECAY = Q30_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
		- EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8;

	localparam int PIPE_STAGES = 7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int TDATA_W    = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;

	localparam logic [PRE_W-1:0] PREGAIN_RST = PRE_W'(307);
	localparam logic [DRV_W-1:0] DRIVE_RST   = DRV_W'(307);
	localparam logic [MIX_W-1:0] MIX_RST     = MIX_W'(MIX_ONE);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PREGAIN  = 3'd0,
		REG_DRIVE    = 3'd1,
		REG_WET_MIX  = 3'd2,
		REG_SOFT_OFF = 3'd3,
		REG_HARD_OFF = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [PRE_W-1:0] pregain;
		logic [DRV_W-1:0] drive_gain;
		logic [MIX_W-1:0] wet_mix;
		logic             soft_off;
		logic             hard_off;
	} cfg_t;

	typedef struct packed {
		logic [PIPE_STAGES-1:0] en;
		logic [PIPE_STAGES-1:0] vld;
	} pipe_stat_t;

	typedef logic [EXP_W-1:0] exp_arr_t [EXP_TABLE_DEPTH];

	// Builds exp(-k*16/DEPTH) by repeated multiplication with the step
	// factor. With want_diff set, entry k holds the drop to entry k+1.
	function automatic exp_arr_t build_exp_tab(input bit want_diff);
		longint   cur;
		longint   nxt;
		exp_arr_t tab;
		cur = Q30_ONE;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			nxt    = (cur * EXP_DECAY + (Q30_ONE >> 1)) >>> 30;
			tab[k] = want_diff ? EXP_W'(cur - nxt) : EXP_W'(cur);
			cur    = nxt;
		end
		return tab;
	endfunction

	localparam exp_arr_t EXP_BASE = build_exp_tab(1'b0);
	localparam exp_arr_t EXP_DIFF = build_exp_tab(1'b1);

endpackage

// ===== hw/rtl/shcd_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shcd_pipe_ctrl: valid tracking for the lane pipeline
// Keeps one valid bit per stage and lets bubbles collapse, so a stalled
// output only holds back the stages that are actually occupied.
// ----------------------------------------------------------------------------
module shcd_pipe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output shcd_pkg::pipe_stat_t stat
);
	import shcd_pkg::*;

	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] rdy;

	// A stage may load when it is empty or when its contents move on.
	always_comb begin
		rdy[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || out_ready;
		for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < PIPE_STAGES; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[PIPE_STAGES-1];
	assign stat.en   = rdy;
	assign stat.vld  = vld_q;

endmodule

// ===== hw/rtl/shcd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shcd_lane: one channel of the distortion datapath
// Seven register stages: pregain, drive, table lookup, interpolation,
// clipping, dry/wet products and final rounding with saturation.
// ----------------------------------------------------------------------------
module shcd_lane (
	input  logic                                      clk,
	input  shcd_pkg::cfg_t                            cfg,
	input  logic [shcd_pkg::PIPE_STAGES-1:0]          en,
	input  logic signed [shcd_pkg::SAMPLE_BITS-1:0]   x,
	output logic signed [shcd_pkg::SAMPLE_BITS-1:0]   y
);
	import shcd_pkg::*;

	localparam int SOFT_SH  = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
	localparam int SOFT_LSH = (FRAC_BITS > 30) ? FRAC_BITS - 30 : 0;
	localparam longint SOFT_HALF = (SOFT_SH > 0) ? (longint'(1) << (SOFT_SH - 1)) : 0;
	localparam logic signed [W_W-1:0] HC_POS = W_W'(longint'(1) << FRAC_BITS);
	localparam logic signed [W_W-1:0] HC_NEG = -HC_POS;
	localparam logic signed [MP_W:0] Y_MAX = (MP_W+1)'((longint'(1) << FRAC_BITS) - 1);
	localparam logic signed [MP_W:0] Y_MIN = -(MP_W+1)'(longint'(1) << FRAC_BITS);

	// Stage registers.
	logic signed [P_W-1:0]            p_s1;
	logic signed [D_W-1:0]            d_s2, d_s3, d_s4, d_s5;
	logic signed [WP_W-1:0]           wp_s2;
	logic signed [W_W-1:0]            w_s3, w_s4;
	logic                             sat_s3, sat_s4;
	logic [EXP_W-1:0]                 a_s3, a_s4;
	logic [EXP_W-1:0]                 df_s3;
	logic [FRAC_BITS-1:0]             frac_s3;
	logic [EXP_W+FRAC_BITS-1:0]       prod_s4;
	logic signed [D_W-1:0]            wet_s5;
	logic signed [MP_W-1:0]           mw_s6, md_s6;
	logic signed [SAMPLE_BITS-1:0]    y_s7;

	// Combinational values between stages.
	logic signed [P_W:0]              p_rnd;
	logic signed [D_W-1:0]            d_nxt;
	logic signed [WP_W-1:0]           wp_nxt;
	logic signed [WP_W:0]             wp_rnd;
	logic signed [W_W-1:0]            w_in;
	logic [W_W-1:0]                   t_mag;
	logic [FRAC_BITS+TAB_AW-1:0]      pos;
	logic [TAB_AW-1:0]                idx;
	logic                             clip_on;
	logic [EXP_W-1:0]                 e_val;
	logic [EXP_W-1:0]                 s_val;
	logic signed [W_W-1:0]            s_mag;
	logic signed [W_W-1:0]            soft_w;
	logic signed [W_W-1:0]            v_soft;
	logic signed [W_W-1:0]            v_hard;
	logic [MIX_W-1:0]                 mix_m;
	logic [MIX_W-1:0]                 mix_d;
	logic signed [MP_W:0]             y_sum;
	logic signed [MP_W:0]             y_wide;

	// Stage 2: round the pregain product, start the drive product.
	always_comb begin
		p_rnd  = (P_W+1)'(p_s1) + (P_W+1)'(1 << (GAIN_SH - 1));
		d_nxt  = D_W'(p_rnd >>> GAIN_SH);
		wp_nxt = WP_W'(d_nxt) * WP_W'($signed({1'b0, cfg.drive_gain}));
	end

	// Stage 3: magnitude, table index and fraction.
	always_comb begin
		clip_on = !(cfg.soft_off && cfg.hard_off);
		wp_rnd  = (WP_W+1)'(wp_s2) + (WP_W+1)'(1 << (GAIN_SH - 1));
		w_in    = clip_on ? W_W'(wp_rnd >>> GAIN_SH) : W_W'(d_s2);
		t_mag   = w_in[W_W-1] ? W_W'(-w_in) : W_W'(w_in);
		pos     = {t_mag[FRAC_BITS+RANGE_SH-1:0], {(TAB_AW - RANGE_SH){1'b0}}};
		idx     = pos[FRAC_BITS+TAB_AW-1:FRAC_BITS];
	end

	// Stage 5: finish the interpolation, apply the soft and hard clips.
	always_comb begin
		e_val  = sat_s4 ? '0 : a_s4 - EXP_W'(prod_s4 >> FRAC_BITS);
		s_val  = EXP_W'(Q30_ONE) - e_val;
		s_mag  = W_W'(((EXP_W+1)'(s_val) + (EXP_W+1)'(SOFT_HALF)) >> SOFT_SH) << SOFT_LSH;
		soft_w = (w_s4 > 0) ? s_mag : -s_mag;
		v_soft = cfg.soft_off ? w_s4 : soft_w;
		if (cfg.hard_off) begin
			v_hard = v_soft;
		end else if (v_soft > HC_POS) begin
			v_hard = HC_POS;
		end else if (v_soft < HC_NEG) begin
			v_hard = HC_NEG;
		end else begin
			v_hard = v_soft;
		end
	end

	// Stages 6 and 7: crossfade weights, rounding and saturation.
	always_comb begin
		mix_m  = (cfg.wet_mix > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : cfg.wet_mix;
		mix_d  = MIX_W'(MIX_ONE) - mix_m;
		y_sum  = (MP_W+1)'(mw_s6) + (MP_W+1)'(md_s6) + (MP_W+1)'(1 << (MIX_SH - 1));
		y_wide = y_sum >>> MIX_SH;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s1 <= P_W'(x) * P_W'($signed({1'b0, cfg.pregain}));
		end
		if (en[1]) begin
			d_s2  <= d_nxt;
			wp_s2 <= wp_nxt;
		end
		if (en[2]) begin
			d_s3    <= d_s2;
			w_s3    <= w_in;
			sat_s3  <= |t_mag[W_W-1:FRAC_BITS+RANGE_SH];
			a_s3    <= EXP_BASE[idx];
			df_s3   <= EXP_DIFF[idx];
			frac_s3 <= pos[FRAC_BITS-1:0];
		end
		if (en[3]) begin
			d_s4    <= d_s3;
			w_s4    <= w_s3;
			sat_s4  <= sat_s3;
			a_s4    <= a_s3;
			prod_s4 <= (EXP_W+FRAC_BITS)'(df_s3) * (EXP_W+FRAC_BITS)'(frac_s3);
		end
		if (en[4]) begin
			d_s5   <= d_s4;
			wet_s5 <= D_W'(v_hard);
		end
		if (en[5]) begin
			mw_s6 <= MP_W'(wet_s5) * MP_W'($signed({1'b0, mix_m}));
			md_s6 <= MP_W'(d_s5) * MP_W'($signed({1'b0, mix_d}));
		end
		if (en[6]) begin
			if (y_wide > Y_MAX) begin
				y_s7 <= SAMPLE_BITS'(Y_MAX);
			end else if (y_wide < Y_MIN) begin
				y_s7 <= SAMPLE_BITS'(Y_MIN);
			end else begin
				y_s7 <= SAMPLE_BITS'(y_wide);
			end
		end
	end

	assign y = y_s7;

endmodule

// ===== hw/rtl/soft_hard_clip_distortion_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_hard_clip_distortion_unit: stereo soft and hard clipping distortion
// Throughput is one stereo word per cycle while the output is not stalled, through the seven-stage lane pipeline.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the
// register defaults: pregain 307, drive_gain 307, wet_mix 4096, both clips on.
// ----------------------------------------------------------------------------
module soft_hard_clip_distortion_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata fields from bit 0 up: left_in (24), right_in (24).
	input  logic [shcd_pkg::TDATA_W-1:0]         s_axis_tdata,
	// Output stream.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tdata fields from bit 0 up: left_out (24), right_out (24).
	output logic [shcd_pkg::TDATA_W-1:0]         m_axis_tdata,
	// Configuration write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [shcd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [shcd_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import shcd_pkg::*;

	cfg_t       cfg_q;
	pipe_stat_t stat;
	logic signed [SAMPLE_BITS-1:0] lane_y [CHANNELS];

	// The register file always takes a write; the lanes read registers live.
	// Users must only change them while no word is in flight; not enforced.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pregain    <= PREGAIN_RST;
			cfg_q.drive_gain <= DRIVE_RST;
			cfg_q.wet_mix    <= MIX_RST;
			cfg_q.soft_off   <= 1'b0;
			cfg_q.hard_off   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PREGAIN: begin
					cfg_q.pregain <= cfg_data[PRE_W-1:0];
				end
				REG_DRIVE: begin
					cfg_q.drive_gain <= cfg_data[DRV_W-1:0];
				end
				REG_WET_MIX: begin
					cfg_q.wet_mix <= cfg_data[MIX_W-1:0];
				end
				REG_SOFT_OFF: begin
					cfg_q.soft_off <= cfg_data[0];
				end
				REG_HARD_OFF: begin
					cfg_q.hard_off <= cfg_data[0];
				end
				default: begin
					// Unused indexes are ignored.
				end
			endcase
		end
	end

	// The control block tracks which stages hold a word and generates the
	// per-stage load enables shared by all lanes.
	shcd_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat)
	);

	// One lane per channel; each works on its own slice of the input word.
	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		shcd_lane u_lane (
			.clk (clk),
			.cfg (cfg_q),
			.en  (stat.en),
			.x   (s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
			.y   (lane_y[c])
		);
	end

	// Merge the lane results into one output word, padding the top with zeros.
	always_comb begin
		m_axis_tdata = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			m_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] = lane_y[c];
		end
	end

	// With the last stage empty, nothing can hold the input back.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while the output stage is empty");

	// An accepted word must occupy the first stage on the next cycle.
	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> stat.vld[0])
		else $error("accepted word did not enter the first stage");

	// A full pipeline facing a stalled output must refuse new words.
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(&stat.vld) && !m_axis_tready |-> !s_axis_tready)
		else $error("full pipeline accepted a word while the output stalled");

endmodule
